// File: src/perspective_vertex_project_macros.svh
// Assertion macros for the perspective vertex projection block.
// Used by the port checker; no other dependencies.
`ifndef PERSPECTIVE_VERTEX_PROJECT_MACROS_SVH
`define PERSPECTIVE_VERTEX_PROJECT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PVP_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pvp assertion failed");

// Next-cycle implication, off while reset is asserted.
`define PVP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pvp assertion failed");

// A cycle in reset leaves the signal low in the next cycle.
`define PVP_ASSERT_RESET(label, clk, rst_n, sig) \
    label: assert property (@(posedge clk) (!rst_n) |=> (!(sig))) \
        else $error("pvp reset assertion failed");

`endif

// File: src/pvp_pkg.sv
// Shared constants, types and helper functions of the perspective vertex projection block.
// No dependencies.
package pvp_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int COORD_WIDTH    = 32;
    // numerator of each division: 32-bit signed scale times a coordinate, plus headroom
    localparam int NUM_W          = COORD_WIDTH + 33;
    localparam int MAG_W          = NUM_W - 1;
    localparam int DEN_W          = COORD_WIDTH;
    localparam int DIV_LAT        = MAG_W + 2;
    localparam int RATIO_LIM_BITS = 48;
    localparam int RATIO_W        = RATIO_LIM_BITS + 2;
    localparam int SIZE_W         = 14;
    localparam int SCR_W          = RATIO_W + SIZE_W + 1;
    localparam int WIDE_W         = (NUM_W > SCR_W) ? NUM_W : SCR_W;
    localparam int TDATA_W        = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT  = CFG_IDX_W'(5);

    localparam logic [30:0]        RST_X_SCALE      = 31'd85133;
    localparam logic [30:0]        RST_Y_SCALE      = 31'd113512;
    localparam logic signed [31:0] RST_DEPTH_SCALE  = -32'sd66195;
    localparam logic signed [31:0] RST_DEPTH_OFFSET = -32'sd65865;
    localparam logic [SIZE_W-1:0]  RST_VIEW_WIDTH   = SIZE_W'(800);
    localparam logic [SIZE_W-1:0]  RST_VIEW_HEIGHT  = SIZE_W'(600);

    typedef struct packed {
        logic [30:0]        x_scale;
        logic [30:0]        y_scale;
        logic signed [31:0] depth_scale;
        logic signed [31:0] depth_offset;
        logic [SIZE_W-1:0]  view_width;
        logic [SIZE_W-1:0]  view_height;
    } cfg_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num_x;
        logic signed [NUM_W-1:0] num_y;
        logic signed [NUM_W-1:0] num_z;
        logic [DEN_W-1:0]        w;
        logic                    behind;
    } qitem_t;

    function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = $signed((WIDE_W'(1) << (COORD_WIDTH - 1)) - WIDE_W'(1));
        lo = ~hi;
        if (v > hi) begin
            return hi[COORD_WIDTH-1:0];
        end else if (v < lo) begin
            return lo[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [RATIO_W-1:0] clamp_ratio(
        input logic signed [NUM_W-1:0] v);
        logic signed [NUM_W-1:0] lim;
        lim = $signed(NUM_W'(1) << RATIO_LIM_BITS);
        if (v > lim) begin
            return RATIO_W'(lim);
        end else if (v < -lim) begin
            return RATIO_W'(-lim);
        end
        return RATIO_W'(v);
    endfunction

endpackage

// File: src/pvp_front.sv
// Front end: accepts vertices, flags those behind the eye, forms the three numerators.
// Depends on pvp_pkg.
module pvp_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pvp_pkg::cfg_t                cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pvp_pkg::TDATA_W-1:0]  s_tdata,
    output logic                         q_push,
    output pvp_pkg::qitem_t              q_item,
    input  logic                         q_ready
);

    logic                                    v1_reg;
    logic signed [pvp_pkg::COORD_WIDTH-1:0]  x1_reg;
    logic signed [pvp_pkg::COORD_WIDTH-1:0]  y1_reg;
    logic signed [pvp_pkg::COORD_WIDTH-1:0]  z1_reg;
    logic                                    v2_reg;
    logic signed [pvp_pkg::NUM_W-1:0]        px2_reg;
    logic signed [pvp_pkg::NUM_W-1:0]        py2_reg;
    logic signed [pvp_pkg::NUM_W-1:0]        pz2_reg;
    logic [pvp_pkg::DEN_W-1:0]               w2_reg;
    logic                                    behind2_reg;
    logic                                    adv;
    logic signed [31:0]                      xs;
    logic signed [31:0]                      ys;
    logic signed [31:0]                      ds;
    logic signed [31:0]                      dof;
    logic signed [pvp_pkg::NUM_W-1:0]        wq;
    logic signed [pvp_pkg::NUM_W-1:0]        off_q;

    assign adv      = !v2_reg || q_ready;
    assign s_tready = adv;
    assign q_push   = v2_reg && q_ready;

    assign xs  = $signed({1'b0, cfg.x_scale});
    assign ys  = $signed({1'b0, cfg.y_scale});
    assign ds  = cfg.depth_scale;
    assign dof = cfg.depth_offset;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg      <= $signed(s_tdata[pvp_pkg::COORD_WIDTH-1:0]);
            y1_reg      <= $signed(s_tdata[2*pvp_pkg::COORD_WIDTH-1:pvp_pkg::COORD_WIDTH]);
            z1_reg      <= $signed(s_tdata[3*pvp_pkg::COORD_WIDTH-1:2*pvp_pkg::COORD_WIDTH]);
            px2_reg     <= xs * x1_reg;
            py2_reg     <= ys * y1_reg;
            pz2_reg     <= ds * z1_reg;
            // clip w is -z; behind the eye when z is zero or positive
            w2_reg      <= pvp_pkg::DEN_W'(-z1_reg);
            behind2_reg <= !z1_reg[pvp_pkg::COORD_WIDTH-1];
        end
    end

    assign wq    = $signed(pvp_pkg::NUM_W'(w2_reg)) <<< pvp_pkg::FRAC_BITS;
    assign off_q = pvp_pkg::NUM_W'(dof) <<< pvp_pkg::FRAC_BITS;

    always_comb begin
        q_item.num_x  = px2_reg + wq;
        q_item.num_y  = wq - py2_reg;
        q_item.num_z  = pz2_reg + off_q;
        q_item.w      = w2_reg;
        q_item.behind = behind2_reg;
    end

endmodule

// File: src/pvp_fifo.sv
// Short queue between the front end and the divide back end.
// Depends on pvp_pkg.
module pvp_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pvp_pkg::qitem_t din,
    output logic            ready,
    output logic            valid,
    output pvp_pkg::qitem_t dout,
    input  logic            pop
);

    logic [pvp_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pvp_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pvp_pkg::QPTR_W:0]   count_reg;
    logic [pvp_pkg::QPTR_W:0]   count_next;
    pvp_pkg::qitem_t            mem_reg [pvp_pkg::QUEUE_DEPTH];

    assign ready = count_reg != (pvp_pkg::QPTR_W + 1)'(pvp_pkg::QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: src/pvp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, floor rounding.
// Depends on pvp_pkg.
module pvp_divider (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [pvp_pkg::NUM_W-1:0] num,
    input  logic [pvp_pkg::DEN_W-1:0]        den,
    output logic signed [pvp_pkg::NUM_W-1:0] quo
);

    logic [pvp_pkg::MAG_W-1:0]        dq_reg  [pvp_pkg::MAG_W+1];
    logic [pvp_pkg::DEN_W-1:0]        rem_reg [pvp_pkg::MAG_W+1];
    logic [pvp_pkg::DEN_W-1:0]        den_reg [pvp_pkg::MAG_W];
    logic                             neg_reg [pvp_pkg::MAG_W+1];
    logic signed [pvp_pkg::NUM_W-1:0] abs_num;
    logic signed [pvp_pkg::NUM_W-1:0] quo_reg;
    logic [pvp_pkg::NUM_W-1:0]        mag_up;

    assign abs_num = num[pvp_pkg::NUM_W-1] ? -num : num;

    always_ff @(posedge aclk) begin
        if (en) begin
            dq_reg[0]  <= abs_num[pvp_pkg::MAG_W-1:0];
            rem_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[pvp_pkg::NUM_W-1];
        end
    end

    for (genvar i = 1; i <= pvp_pkg::MAG_W; i++) begin : g_step
        logic [pvp_pkg::DEN_W:0] trial;
        logic                    ge;
        logic [pvp_pkg::DEN_W:0] diff;

        assign trial = {rem_reg[i-1], dq_reg[i-1][pvp_pkg::MAG_W-1]};
        assign ge    = trial >= {1'b0, den_reg[i-1]};
        assign diff  = trial - {1'b0, den_reg[i-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? diff[pvp_pkg::DEN_W-1:0] : trial[pvp_pkg::DEN_W-1:0];
                dq_reg[i]  <= {dq_reg[i-1][pvp_pkg::MAG_W-2:0], ge};
                neg_reg[i] <= neg_reg[i-1];
            end
        end

        if (i < pvp_pkg::MAG_W) begin : g_den
            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[i] <= den_reg[i-1];
                end
            end
        end
    end

    // negative numerator: round the magnitude quotient up when a remainder is left
    assign mag_up = pvp_pkg::NUM_W'(dq_reg[pvp_pkg::MAG_W])
                  + pvp_pkg::NUM_W'(rem_reg[pvp_pkg::MAG_W] != '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= neg_reg[pvp_pkg::MAG_W] ? -$signed(mag_up)
                                               : $signed(pvp_pkg::NUM_W'(dq_reg[pvp_pkg::MAG_W]));
        end
    end

    assign quo = quo_reg;

endmodule

// File: src/pvp_back.sv
// Back end: three dividers, viewport scaling, saturation and the output register.
// Depends on pvp_pkg and pvp_divider.
module pvp_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pvp_pkg::SIZE_W-1:0]   view_width,
    input  logic [pvp_pkg::SIZE_W-1:0]   view_height,
    input  logic                         q_valid,
    input  pvp_pkg::qitem_t              q_item,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pvp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tuser
);

    logic                                   en;
    logic [pvp_pkg::DIV_LAT-1:0]            sv_reg;
    logic [pvp_pkg::DIV_LAT-1:0]            sb_reg;
    logic signed [pvp_pkg::NUM_W-1:0]       quo_x;
    logic signed [pvp_pkg::NUM_W-1:0]       quo_y;
    logic signed [pvp_pkg::NUM_W-1:0]       quo_z;
    logic                                   p1_valid_reg;
    logic                                   p1_behind_reg;
    logic signed [pvp_pkg::SCR_W-1:0]       sx1_reg;
    logic signed [pvp_pkg::SCR_W-1:0]       sy1_reg;
    logic signed [pvp_pkg::NUM_W-1:0]       qz1_reg;
    logic signed [pvp_pkg::SCR_W-1:0]       sx_half;
    logic signed [pvp_pkg::SCR_W-1:0]       sy_half;
    logic                                   m_tvalid_reg;
    logic                                   behind_reg;
    logic [pvp_pkg::COORD_WIDTH-1:0]        sx_out_reg;
    logic [pvp_pkg::COORD_WIDTH-1:0]        sy_out_reg;
    logic [pvp_pkg::COORD_WIDTH-1:0]        dz_out_reg;

    assign en    = !m_tvalid_reg || m_tready;
    assign q_pop = en && q_valid;

    pvp_divider u_div_x (.aclk(aclk), .en(en), .num(q_item.num_x), .den(q_item.w), .quo(quo_x));
    pvp_divider u_div_y (.aclk(aclk), .en(en), .num(q_item.num_y), .den(q_item.w), .quo(quo_y));
    pvp_divider u_div_z (.aclk(aclk), .en(en), .num(q_item.num_z), .den(q_item.w), .quo(quo_z));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg       <= '0;
            p1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            sv_reg       <= {sv_reg[pvp_pkg::DIV_LAT-2:0], q_valid};
            p1_valid_reg <= sv_reg[pvp_pkg::DIV_LAT-1];
            m_tvalid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg        <= {sb_reg[pvp_pkg::DIV_LAT-2:0], q_item.behind};
            p1_behind_reg <= sb_reg[pvp_pkg::DIV_LAT-1];
            sx1_reg       <= pvp_pkg::clamp_ratio(quo_x) * $signed({1'b0, view_width});
            sy1_reg       <= pvp_pkg::clamp_ratio(quo_y) * $signed({1'b0, view_height});
            qz1_reg       <= quo_z;
        end
    end

    // halve with floor rounding
    assign sx_half = sx1_reg >>> 1;
    assign sy_half = sy1_reg >>> 1;

    always_ff @(posedge aclk) begin
        if (en) begin
            behind_reg <= p1_behind_reg;
            if (p1_behind_reg) begin
                sx_out_reg <= '0;
                sy_out_reg <= '0;
                dz_out_reg <= '0;
            end else begin
                sx_out_reg <= pvp_pkg::sat_coord(pvp_pkg::WIDE_W'(sx_half));
                sy_out_reg <= pvp_pkg::sat_coord(pvp_pkg::WIDE_W'(sy_half));
                dz_out_reg <= pvp_pkg::sat_coord(pvp_pkg::WIDE_W'(qz1_reg));
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = behind_reg;
    assign m_tdata  = pvp_pkg::TDATA_W'({dz_out_reg, sy_out_reg, sx_out_reg});

endmodule

// File: src/perspective_vertex_project.sv
// Perspective projection and viewport mapping of view-space vertices.
// Throughput: one vertex per cycle unless the output stalls; the three dividers retire one quotient bit per stage.
// A stalled output holds the whole back end; the queue absorbs the front end's items.
// Reset (aresetn low, synchronous) empties all stages and restores the matrix registers.
// Depends on pvp_pkg, pvp_front, pvp_fifo, pvp_back.
module perspective_vertex_project (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [pvp_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [pvp_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // vertex input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pvp_pkg::TDATA_W-1:0]     s_tdata,   // vert_x, vert_y, vert_z
    // projected result
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pvp_pkg::TDATA_W-1:0]     m_tdata,   // screen_x, screen_y, depth_ndc
    output logic                            m_tuser    // behind_eye
);

    pvp_pkg::cfg_t   cfg_reg;
    pvp_pkg::qitem_t front_item;
    pvp_pkg::qitem_t queue_item;
    logic            q_push;
    logic            q_ready;
    logic            q_valid;
    logic            q_pop;

    // Matrix and viewport registers; writes to unknown indexes drop silently.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_scale      <= pvp_pkg::RST_X_SCALE;
            cfg_reg.y_scale      <= pvp_pkg::RST_Y_SCALE;
            cfg_reg.depth_scale  <= pvp_pkg::RST_DEPTH_SCALE;
            cfg_reg.depth_offset <= pvp_pkg::RST_DEPTH_OFFSET;
            cfg_reg.view_width   <= pvp_pkg::RST_VIEW_WIDTH;
            cfg_reg.view_height  <= pvp_pkg::RST_VIEW_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                pvp_pkg::REG_X_SCALE:      cfg_reg.x_scale      <= cfg_wr_data[30:0];
                pvp_pkg::REG_Y_SCALE:      cfg_reg.y_scale      <= cfg_wr_data[30:0];
                pvp_pkg::REG_DEPTH_SCALE:  cfg_reg.depth_scale  <= $signed(cfg_wr_data[31:0]);
                pvp_pkg::REG_DEPTH_OFFSET: cfg_reg.depth_offset <= $signed(cfg_wr_data[31:0]);
                pvp_pkg::REG_VIEW_WIDTH:   cfg_reg.view_width   <= cfg_wr_data[pvp_pkg::SIZE_W-1:0];
                pvp_pkg::REG_VIEW_HEIGHT:  cfg_reg.view_height  <= cfg_wr_data[pvp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: register the vertex, multiply by the matrix, form numerators.
    pvp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_item   (front_item),
        .q_ready  (q_ready)
    );

    // Queue decouples the front end from output backpressure.
    pvp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (front_item),
        .ready   (q_ready),
        .valid   (q_valid),
        .dout    (queue_item),
        .pop     (q_pop)
    );

    // Back end: divide by w, scale to the viewport, saturate, hold the result.
    pvp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .view_width  (cfg_reg.view_width),
        .view_height (cfg_reg.view_height),
        .q_valid     (q_valid),
        .q_item      (queue_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// File: src/pvp_checker.sv
// Port-level checker for the perspective vertex projection block, bound to the top level.
// Depends on pvp_pkg and the assertion macro header.
`include "perspective_vertex_project_macros.svh"

module pvp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pvp_pkg::TDATA_W-1:0]  m_tdata,
    input logic                         m_tuser
);

    `PVP_ASSERT_RESET(a_reset_clears_out, aclk, aresetn, m_tvalid)
    `PVP_ASSERT_SAME(a_behind_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `PVP_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind perspective_vertex_project pvp_checker u_pvp_checker (.*);
